// ===== rtl/pit_pkg.sv =====
// ----------------------------------------------------------------------------
// pit_pkg: shared types and constants of the interval timer
// Codes for actions, ports and time units, control bit positions, divider
// handshake structs and the per-unit nanosecond divisor.
// ----------------------------------------------------------------------------
package pit_pkg;

   // counter width of the down-counter (8..32)
   localparam int COUNT_WIDTH = 32;
   localparam int DATA_W      = 32;
   localparam int NS_W        = 64;
   // divisor width: large enough for one second in ns
   localparam int DIV_W       = 30;
   localparam int DIV_STEPS   = NS_W;
   localparam int STEP_W      = $clog2(DIV_STEPS);

   // action codes
   localparam logic [1:0] ACT_TICK  = 2'd0;
   localparam logic [1:0] ACT_READ  = 2'd1;
   localparam logic [1:0] ACT_WRITE = 2'd2;

   // port select codes
   localparam logic PORT_CTRL  = 1'b0;
   localparam logic PORT_COUNT = 1'b1;

   // time unit codes
   localparam logic [1:0] UNIT_US     = 2'd0;
   localparam logic [1:0] UNIT_MS     = 2'd1;
   localparam logic [1:0] UNIT_SEC    = 2'd2;
   localparam logic [1:0] UNIT_CYCLES = 2'd3;

   // control byte bit positions
   localparam int CTL_ENABLE_BIT  = 7;
   localparam int CTL_IRQ_EN_BIT  = 6;
   localparam int CTL_ONESHOT_BIT = 5;
   localparam int CTL_UNIT_HI     = 4;
   localparam int CTL_UNIT_LO     = 3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_EMIT
   } pit_state_type;

   typedef struct packed {
      logic       start;
      logic [1:0] unit;
   } pit_div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } pit_div_stat_type;

   // nanoseconds per unit; cycle unit never reaches the divider
   function automatic logic [DIV_W-1:0] unit_divisor(input logic [1:0] unit);
      logic [DIV_W-1:0] d;
      unique case (unit)
         UNIT_US: d = DIV_W'(1000);
         UNIT_MS: d = DIV_W'(1000000);
         default: d = DIV_W'(1000000000);
      endcase
      return d;
   endfunction

endpackage

// ===== rtl/pit_req_if.sv =====
// ----------------------------------------------------------------------------
// pit_req_if: request channel of the interval timer
// Valid/ready channel carrying one port access or tick per beat.
// ----------------------------------------------------------------------------
interface pit_req_if;
   import pit_pkg::*;

   logic              valid;
   logic              ready;
   logic [1:0]        action;
   logic              port_sel;
   logic [DATA_W-1:0] write_data;
   logic [NS_W-1:0]   now_ns;
   logic [DATA_W-1:0] elapsed_cycles;

   modport source (
      output valid, action, port_sel, write_data, now_ns, elapsed_cycles,
      input  ready
   );

   modport sink (
      input  valid, action, port_sel, write_data, now_ns, elapsed_cycles,
      output ready
   );

endinterface

// ===== rtl/pit_rsp_if.sv =====
// ----------------------------------------------------------------------------
// pit_rsp_if: response channel of the interval timer
// Valid/ready channel carrying read data and the interrupt flag per beat.
// ----------------------------------------------------------------------------
interface pit_rsp_if;
   import pit_pkg::*;

   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] read_data;
   logic              irq_raise;

   modport source (
      output valid, read_data, irq_raise,
      input  ready
   );

   modport sink (
      input  valid, read_data, irq_raise,
      output ready
   );

endinterface

// ===== rtl/interval_timer_with_reload_unit.sv =====
// ----------------------------------------------------------------------------
// interval_timer_with_reload_unit: programmable down-counting interval timer
// Control byte and reload/counter ports plus ticks on one request channel.
// Flow: reads, writes, disabled ticks and cycle-unit ticks pass through
//   ST_EMIT into the output register; time-unit ticks first pass through
//   ST_DIV for the 64-step bit-serial division of the nanosecond remainder.
// Throughput: one request at a time; the next is taken the cycle after the
//   response is loaded into the output register.
// Reset (synchronous, active high) clears all timer state and the time base.
// ----------------------------------------------------------------------------
module interval_timer_with_reload_unit (
   input logic clock,
   input logic reset,
   pit_req_if.sink   req_ch,
   pit_rsp_if.source rsp_ch
);
   import pit_pkg::*;

   localparam int CW = COUNT_WIDTH;

   pit_state_type     state_ff, state_in;
   logic [7:0]        ctrl_ff, ctrl_in;
   logic [DATA_W-1:0] reload_ff, reload_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [NS_W-1:0]   ns_rem_ff, ns_rem_in;
   logic [NS_W-1:0]   last_ff, last_in;
   logic              pend_ff, pend_in;
   logic              fired_ff, fired_in;
   logic              loaded_ff, loaded_in;
   logic [DATA_W-1:0] res_data_ff, res_data_in;
   logic              res_irq_ff, res_irq_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_irq_ff, rsp_irq_in;

   pit_div_ctl_type   div_ctl;
   pit_div_stat_type  div_stat;
   logic [NS_W-1:0]   div_dividend;
   logic [NS_W-1:0]   div_quot;
   logic [DIV_W-1:0]  div_rem;

   logic              accept;
   logic [1:0]        unit;
   logic [CW-1:0]     cnt_base;
   logic              post_go;
   logic [CW-1:0]     post_src;

   assign unit   = ctrl_ff[CTL_UNIT_HI:CTL_UNIT_LO];
   assign accept = req_ch.valid && req_ch.ready;

   pit_serdiv u_div (
      .clock     (clock),
      .reset     (reset),
      .div_ctl   (div_ctl),
      .dividend  (div_dividend),
      .div_stat  (div_stat),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // timer state and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff      <= '0;
         reload_ff    <= '0;
         count_ff     <= '0;
         ns_rem_ff    <= '0;
         last_ff      <= '0;
         pend_ff      <= 1'b0;
         fired_ff     <= 1'b0;
         loaded_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ctrl_ff      <= ctrl_in;
         reload_ff    <= reload_in;
         count_ff     <= count_in;
         ns_rem_ff    <= ns_rem_in;
         last_ff      <= last_in;
         pend_ff      <= pend_in;
         fired_ff     <= fired_in;
         loaded_ff    <= loaded_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result and output payload
   always_ff @(posedge clock) begin
      res_data_ff <= res_data_in;
      res_irq_ff  <= res_irq_in;
      rsp_data_ff <= rsp_data_in;
      rsp_irq_ff  <= rsp_irq_in;
   end

   // next state, timer update and handshakes
   always_comb begin
      state_in     = state_ff;
      ctrl_in      = ctrl_ff;
      reload_in    = reload_ff;
      count_in     = count_ff;
      ns_rem_in    = ns_rem_ff;
      last_in      = last_ff;
      pend_in      = pend_ff;
      fired_in     = fired_ff;
      loaded_in    = loaded_ff;
      res_data_in  = res_data_ff;
      res_irq_in   = res_irq_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_data_in  = rsp_data_ff;
      rsp_irq_in   = rsp_irq_ff;
      req_ch.ready = 1'b0;
      div_ctl      = '{start: 1'b0, unit: unit};
      div_dividend = ns_rem_ff + (req_ch.now_ns - last_ff);
      cnt_base     = pend_ff ? CW'(reload_ff) : count_ff;
      post_go      = 1'b0;
      post_src     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (accept) begin
               res_data_in = '0;
               res_irq_in  = 1'b0;
               state_in    = ST_EMIT;
               unique case (req_ch.action)
                  ACT_TICK: begin
                     if (ctrl_ff[CTL_ENABLE_BIT]) begin
                        // apply an armed reload first
                        count_in  = cnt_base;
                        pend_in   = 1'b0;
                        loaded_in = loaded_ff || pend_ff;
                        if (unit == UNIT_CYCLES) begin
                           post_go  = 1'b1;
                           post_src = (req_ch.elapsed_cycles >= DATA_W'(cnt_base)) ? '0 :
                                      cnt_base - CW'(req_ch.elapsed_cycles);
                        end else begin
                           last_in       = req_ch.now_ns;
                           div_ctl.start = 1'b1;
                           state_in      = ST_DIV;
                        end
                     end
                  end
                  ACT_READ: begin
                     res_data_in = (req_ch.port_sel == PORT_CTRL) ? DATA_W'(ctrl_ff) :
                                   DATA_W'(count_ff);
                  end
                  ACT_WRITE: begin
                     fired_in = 1'b0;
                     if (req_ch.port_sel == PORT_CTRL) begin
                        ctrl_in = req_ch.write_data[7:0];
                     end else begin
                        reload_in = req_ch.write_data;
                        pend_in   = 1'b1;
                        loaded_in = 1'b1;
                     end
                  end
                  default: begin
                     // unused action: empty response
                  end
               endcase
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               post_go   = 1'b1;
               post_src  = (div_quot >= NS_W'(count_ff)) ? '0 : count_ff - CW'(div_quot);
               ns_rem_in = NS_W'(div_rem);
               state_in  = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_data_ff;
               rsp_irq_in   = res_irq_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // expiry: interrupt if enabled (once in one-shot mode), then hold at zero or reload
      if (post_go) begin
         if (post_src == '0) begin
            res_irq_in = ctrl_ff[CTL_IRQ_EN_BIT] && !fired_ff && loaded_in;
            if (ctrl_ff[CTL_ONESHOT_BIT]) begin
               count_in = '0;
               fired_in = 1'b1;
            end else begin
               count_in = CW'(reload_ff);
               fired_in = 1'b0;
            end
         end else begin
            count_in = post_src;
         end
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.read_data = rsp_data_ff;
   assign rsp_ch.irq_raise = rsp_irq_ff;

   // fired flag only exists in one-shot mode
   a_fired_oneshot: assert property (@(posedge clock) disable iff (reset)
      fired_ff |-> ctrl_ff[CTL_ONESHOT_BIT])
      else $error("fired flag set outside one-shot mode");

   // divider runs only for an enabled time-unit tick
   a_div_enabled: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> ctrl_ff[CTL_ENABLE_BIT] && unit != UNIT_CYCLES
                             && (div_stat.busy || div_stat.done))
      else $error("divider state without an enabled time tick");

   // an interrupt beat never carries read data
   a_irq_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_irq_ff |-> rsp_data_ff == '0)
      else $error("interrupt beat with read data");

endmodule

// ===== rtl/pit_serdiv.sv =====
// ----------------------------------------------------------------------------
// pit_serdiv: bit-serial divider of the nanosecond remainder
// Restoring division, one quotient bit per cycle, MSB first. The dividend
// shifts out of the top of the shift register while quotient bits enter below.
// ----------------------------------------------------------------------------
module pit_serdiv (
   input  logic                        clock,
   input  logic                        reset,
   input  pit_pkg::pit_div_ctl_type    div_ctl,
   input  logic [pit_pkg::NS_W-1:0]    dividend,
   output pit_pkg::pit_div_stat_type   div_stat,
   output logic [pit_pkg::NS_W-1:0]    quotient,
   output logic [pit_pkg::DIV_W-1:0]   remainder
);
   import pit_pkg::*;

   logic              busy_ff;
   logic              done_ff;
   logic [STEP_W-1:0] cnt_ff;
   logic [NS_W-1:0]   dvd_ff, dvd_in;
   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [DIV_W-1:0]  div_ff;
   logic [DIV_W:0]    trial;
   logic [DIV_W:0]    diff;
   logic              q_bit;

   // one restoring step
   always_comb begin
      trial  = {rem_ff, dvd_ff[NS_W-1]};
      diff   = trial - {1'b0, div_ff};
      q_bit  = (trial >= {1'b0, div_ff});
      rem_in = q_bit ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      dvd_in = {dvd_ff[NS_W-2:0], q_bit};
   end

   // step control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (div_ctl.start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + STEP_W'(1);
         if (cnt_ff == STEP_W'(DIV_STEPS - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   // shift registers
   always_ff @(posedge clock) begin
      if (div_ctl.start) begin
         dvd_ff <= dividend;
         rem_ff <= '0;
         div_ff <= unit_divisor(div_ctl.unit);
      end else if (busy_ff) begin
         dvd_ff <= dvd_in;
         rem_ff <= rem_in;
      end
   end

   assign div_stat.busy = busy_ff;
   assign div_stat.done = done_ff;
   assign quotient      = dvd_ff;
   assign remainder     = rem_ff;

   // partial remainder always below the divisor
   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> rem_ff < div_ff)
      else $error("partial remainder not below divisor");

   // done is a single pulse after the last step
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff && $past(busy_ff))
      else $error("divider done without a finished run");

   // step counter wraps back to zero at the end of a run
   a_cnt_idle_zero: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> cnt_ff == '0)
      else $error("step counter not cleared while idle");

endmodule
